/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers shared by the odometry rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ASSERT_STD(lbl, prop, msg) `ASSERT_AT(lbl, clk_i, rst_ni, prop, msg)
`else
`define ASSERT_AT(lbl, clk, rstn, prop, msg)
`define ASSERT_STD(lbl, prop, msg)
`endif
`endif

/* sv/ofo_pkg.sv */
// ----------------------------------------------------------------------------
// ofo_pkg
// widths, register indexes and the arctangent table of the odometry block
// ----------------------------------------------------------------------------
package ofo_pkg;

  localparam int DMAG_W = 40;
  localparam int CW     = 44;
  localparam int ZW     = 34;
  localparam int MA_W   = 33;
  localparam int MB_W   = 25;
  localparam int MP_W   = 58;
  localparam int EL_W   = 16;

  localparam logic [1:0] CFG_SCALE_GAIN   = 2'd0;
  localparam logic [1:0] CFG_MIN_QUALITY  = 2'd1;
  localparam logic [1:0] CFG_FILTER_ALPHA = 2'd2;
  localparam logic [1:0] CFG_MOVE_THR     = 2'd3;

  localparam logic [15:0] INV_GAIN = 16'd39797;

  function automatic logic signed [ZW-1:0] atan_lut(input logic [4:0] idx);
    logic signed [ZW-1:0] r;
    case (idx)
      5'd0:  r = 34'sd536870912;
      5'd1:  r = 34'sd316933406;
      5'd2:  r = 34'sd167458907;
      5'd3:  r = 34'sd85004756;
      5'd4:  r = 34'sd42667331;
      5'd5:  r = 34'sd21354465;
      5'd6:  r = 34'sd10679838;
      5'd7:  r = 34'sd5340245;
      5'd8:  r = 34'sd2670163;
      5'd9:  r = 34'sd1335087;
      5'd10: r = 34'sd667544;
      5'd11: r = 34'sd333772;
      5'd12: r = 34'sd166886;
      5'd13: r = 34'sd83443;
      5'd14: r = 34'sd41722;
      5'd15: r = 34'sd20861;
      5'd16: r = 34'sd10430;
      5'd17: r = 34'sd5215;
      5'd18: r = 34'sd2608;
      5'd19: r = 34'sd1304;
      5'd20: r = 34'sd652;
      5'd21: r = 34'sd326;
      5'd22: r = 34'sd163;
      5'd23: r = 34'sd81;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

/* sv/ofo_mul.sv */
// ----------------------------------------------------------------------------
// ofo_mul
// shared signed multiplier with a registered product
// ----------------------------------------------------------------------------
module ofo_mul (
  input  logic                           clk_i,
  input  logic signed [ofo_pkg::MA_W-1:0] a_i,
  input  logic signed [ofo_pkg::MB_W-1:0] b_i,
  output logic signed [ofo_pkg::MP_W-1:0] p_o
);
  import ofo_pkg::*;

  always_ff @(posedge clk_i) begin
    p_o <= MP_W'(a_i * b_i);
  end

endmodule

/* sv/ofo_div.sv */
// ----------------------------------------------------------------------------
// ofo_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module ofo_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [ofo_pkg::DMAG_W-1:0]  dividend_i,
  input  logic [ofo_pkg::EL_W-1:0]    divisor_i,
  output logic                        done_o,
  output logic [ofo_pkg::DMAG_W-1:0]  quot_o
);
  import ofo_pkg::*;

  logic              busy_q;
  logic [5:0]        cnt_q;
  logic [EL_W-1:0]   div_q;
  logic [EL_W-1:0]   rem_q;
  logic [DMAG_W-1:0] quo_q;
  logic [EL_W:0]     rem_sh;
  logic              fits;

  assign rem_sh = {rem_q, quo_q[DMAG_W-1]};
  assign fits   = rem_sh >= {1'b0, div_q};
  assign quot_o = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'(DMAG_W - 1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q <= divisor_i;
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= fits ? EL_W'(rem_sh - {1'b0, div_q}) : rem_sh[EL_W-1:0];
      quo_q <= {quo_q[DMAG_W-2:0], fits};
    end
  end

endmodule

/* sv/ofo_cordic.sv */
// ----------------------------------------------------------------------------
// ofo_cordic
// vectoring cordic, one micro-rotation per cycle
// ----------------------------------------------------------------------------
module ofo_cordic #(
  parameter int NSTEP = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic signed [ofo_pkg::CW-1:0] x0_i,
  input  logic signed [ofo_pkg::CW-1:0] y0_i,
  output logic                          done_o,
  output logic signed [ofo_pkg::CW-1:0] x_o,
  output logic signed [ofo_pkg::ZW-1:0] z_o
);
  import ofo_pkg::*;

  logic                 busy_q;
  logic [4:0]           i_q;
  logic signed [CW-1:0] x_q, y_q, xs, ys;
  logic signed [ZW-1:0] z_q, at;

  assign xs  = x_q >>> i_q;
  assign ys  = y_q >>> i_q;
  assign at  = atan_lut(i_q);
  assign x_o = x_q;
  assign z_o = z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      i_q    <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        i_q    <= '0;
      end else if (busy_q) begin
        i_q <= i_q + 5'd1;
        if (i_q == 5'(NSTEP - 1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= x0_i;
      y_q <= y0_i;
      z_q <= '0;
    end else if (busy_q) begin
      if (!y_q[CW-1] && (y_q != '0)) begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + at;
      end else if (y_q[CW-1]) begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - at;
      end
    end
  end

endmodule

/* sv/optical_flow_odometry.sv */
// ----------------------------------------------------------------------------
// optical_flow_odometry
// flow-sensor dead reckoning: scaled deltas, filtered velocity, position,
// path length and heading, built around one multiplier, a divider and a cordic
// ----------------------------------------------------------------------------
// channel  dir  handshake                   contents
// s_axis   in   tvalid/tready               one sensor reading
// m_axis   out  tvalid/tready               odometry state after the reading
// cfg      in   cfg_we_i                    register write, no read-back
//
// an accepted reading is scaled axis by axis (m1, m2, m3); when elapsed is
// nonzero each axis then also runs the bit-serial divider and the filter (f0-f2);
// after both axes come position, cordic, magnitude and heading
// a rejected reading goes straight to the done state; tready is low while one is in work
// one finished result waits in the output register while the next is taken
`include "assert_macros.svh"
module optical_flow_odometry #(
  parameter int CORDIC_STEPS = 16,
  parameter int ACCUM_WIDTH  = 40
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // delta_x, delta_y, quality, altitude_mm, elapsed_ms
  input  logic [71:0]  s_axis_tdata,
  // motion_flag, clear
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // position_x_um, position_y_um, velocity_x_mms, velocity_y_mms,
  // heading_angle, distance_um
  output logic [199:0] m_axis_tdata,
  // valid_res
  output logic [0:0]   m_axis_tuser,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [23:0]  cfg_data_i
);
  import ofo_pkg::*;

  localparam int NSTEP = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
  localparam int PW    = ACCUM_WIDTH;
  localparam logic signed [65:0] PMAX = (66'sd1 <<< (PW - 1)) - 66'sd1;
  localparam logic signed [65:0] PMIN = -PMAX - 66'sd1;
  localparam logic [65:0] UMAX = (66'd1 << PW) - 66'd1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_M1   = 4'd1;
  localparam logic [3:0] S_M2   = 4'd2;
  localparam logic [3:0] S_M3   = 4'd3;
  localparam logic [3:0] S_DIV  = 4'd4;
  localparam logic [3:0] S_F0   = 4'd5;
  localparam logic [3:0] S_F1   = 4'd6;
  localparam logic [3:0] S_F2   = 4'd7;
  localparam logic [3:0] S_POS  = 4'd8;
  localparam logic [3:0] S_COR  = 4'd9;
  localparam logic [3:0] S_G0   = 4'd10;
  localparam logic [3:0] S_G1   = 4'd11;
  localparam logic [3:0] S_G2   = 4'd12;
  localparam logic [3:0] S_DONE = 4'd13;

  logic [3:0]  state_q, state_d;
  logic [23:0] gain_q;
  logic [7:0]  minq_q;
  logic [15:0] alpha_q, thr_q;

  logic signed [15:0] raw_q [2];
  logic [15:0]        alt_q, el_q;
  logic               ax_q, valid_q;
  logic [DMAG_W-1:0]  dmag_q [2];
  logic               dneg_q [2];
  logic signed [31:0] filt_q [2];
  logic signed [31:0] v_q;
  logic signed [PW-1:0] pos_q [2];
  logic [PW-1:0]      path_q;
  logic [15:0]        head_q;
  logic [41:0]        xr_q;
  logic signed [ZW-1:0] zr_q;
  logic signed [MP_W-1:0] acc_q;

  logic accept, ok, out_free, last_ax;
  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;
  logic signed [MP_W-1:0] prod;
  logic signed [16:0] rs;
  logic [16:0]        rabs;
  logic [55:0]        ssum;
  logic [DMAG_W-1:0]  smag;
  logic               div_start, div_done, cor_start, cor_done;
  logic [DMAG_W-1:0]  quot;
  logic signed [31:0] vsat;
  logic signed [49:0] fs;
  logic [49:0]        fm;
  logic [33:0]        fr;
  logic signed [31:0] fnew;
  logic signed [CW-1:0] cx0, cy0, cx, cy0_abs;
  logic signed [ZW-1:0] cz;
  logic signed [65:0] psum [2];
  logic [59:0]        gtot;
  logic [43:0]        gmag;
  logic [65:0]        usum;
  logic signed [ZW-1:0] hz;
  logic [15:0]        hnew;
  logic signed [65:0] px_ext, py_ext;
  logic [65:0]        path_ext;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign ok            = s_axis_tuser[0] && (s_axis_tdata[39:32] >= minq_q);
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign last_ax       = ax_q;

  // magnitude of the raw delta of the axis in work
  assign rs   = {raw_q[ax_q][15], raw_q[ax_q]};
  assign rabs = rs[16] ? 17'(-rs) : 17'(rs);
  assign ssum = prod[55:0] + 56'd32768;
  assign smag = ssum[55:16];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_M1: begin
        mul_a = MA_W'(rabs);
        mul_b = MB_W'(alt_q);
      end
      S_M2: begin
        mul_a = {1'b0, prod[31:0]};
        mul_b = {1'b0, gain_q};
      end
      S_F0: begin
        mul_a = MA_W'(filt_q[ax_q]);
        mul_b = MB_W'(alpha_q);
      end
      S_F1: begin
        mul_a = MA_W'(v_q);
        mul_b = MB_W'(17'(18'd65536 - 18'(alpha_q)));
      end
      S_G0: begin
        mul_a = MA_W'(xr_q[20:0]);
        mul_b = MB_W'(INV_GAIN);
      end
      S_G1: begin
        mul_a = MA_W'(xr_q[41:21]);
        mul_b = MB_W'(INV_GAIN);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  ofo_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  assign div_start = (state_q == S_M3) && (el_q != '0);

  ofo_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (smag),
    .divisor_i  (el_q),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // quotient back to a signed velocity, saturated
  always_comb begin
    if (!dneg_q[ax_q]) begin
      vsat = (quot > 40'h007FFFFFFF) ? 32'sh7FFFFFFF : $signed(quot[31:0]);
    end else begin
      vsat = (quot > 40'h0080000000) ? 32'sh80000000 : $signed(32'(-quot[31:0]));
    end
  end

  // filter sum, rounded half away from zero and saturated
  assign fs = acc_q[49:0] + prod[49:0];
  assign fm = fs[49] ? 50'(-fs) : 50'(fs);
  assign fr = 34'((fm + 50'd32768) >> 16);
  always_comb begin
    if (fs[49]) begin
      fnew = (fr > 34'h080000000) ? 32'sh80000000 : $signed(32'(-fr[31:0]));
    end else begin
      fnew = (fr > 34'h07FFFFFFF) ? 32'sh7FFFFFFF : $signed(fr[31:0]);
    end
  end

  assign cor_start = (state_q == S_POS);
  assign cx0       = $signed(CW'(dmag_q[0]));
  assign cy0_abs   = $signed(CW'(dmag_q[1]));
  assign cy0       = dneg_q[1] ? -cy0_abs : cy0_abs;

  ofo_cordic #(
    .NSTEP (NSTEP)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .x0_i    (cx0),
    .y0_i    (cy0),
    .done_o  (cor_done),
    .x_o     (cx),
    .z_o     (cz)
  );

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      psum[k] = 66'(pos_q[k]) + (dneg_q[k] ? -$signed(66'(dmag_q[k]))
                                           : $signed(66'(dmag_q[k])));
    end
  end

  assign gtot = 60'(acc_q) + (60'(prod) << 21) + 60'd32768;
  assign gmag = gtot[59:16];
  assign usum = 66'(path_q) + 66'(gmag);
  assign hz   = (zr_q + 34'sd32768) >>> 16;
  assign hnew = (dneg_q[0] && (dmag_q[0] != '0)) ? 16'(16'h8000 - hz[15:0]) : hz[15:0];

  assign px_ext   = 66'(pos_q[0]);
  assign py_ext   = 66'(pos_q[1]);
  assign path_ext = 66'(path_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (accept) state_d = ok ? S_M1 : S_DONE;
      S_M1:   state_d = S_M2;
      S_M2:   state_d = S_M3;
      S_M3: begin
        if (el_q != '0) state_d = S_DIV;
        else            state_d = last_ax ? S_POS : S_M1;
      end
      S_DIV:  if (div_done) state_d = S_F0;
      S_F0:   state_d = S_F1;
      S_F1:   state_d = S_F2;
      S_F2:   state_d = last_ax ? S_POS : S_M1;
      S_POS:  state_d = S_COR;
      S_COR:  if (cor_done) state_d = S_G0;
      S_G0:   state_d = S_G1;
      S_G1:   state_d = S_G2;
      S_G2:   state_d = S_DONE;
      S_DONE: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      gain_q        <= 24'd65536;
      minq_q        <= 8'd30;
      alpha_q       <= 16'd52429;
      thr_q         <= 16'd1000;
      pos_q[0]      <= '0;
      pos_q[1]      <= '0;
      path_q        <= '0;
      head_q        <= '0;
      filt_q[0]     <= '0;
      filt_q[1]     <= '0;
      ax_q          <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SCALE_GAIN:   gain_q  <= cfg_data_i;
          CFG_MIN_QUALITY:  minq_q  <= cfg_data_i[7:0];
          CFG_FILTER_ALPHA: alpha_q <= cfg_data_i[15:0];
          CFG_MOVE_THR:     thr_q   <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if ((state_q == S_DONE) && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          ax_q <= 1'b0;
          if (accept && s_axis_tuser[1]) begin
            pos_q[0]  <= '0;
            pos_q[1]  <= '0;
            path_q    <= '0;
            head_q    <= '0;
            filt_q[0] <= '0;
            filt_q[1] <= '0;
          end
        end
        S_M3: if (el_q == '0) ax_q <= 1'b1;
        S_F2: begin
          filt_q[ax_q] <= fnew;
          ax_q         <= 1'b1;
        end
        S_POS: begin
          for (int k = 0; k < 2; k++) begin
            if (psum[k] > PMAX)      pos_q[k] <= PMAX[PW-1:0];
            else if (psum[k] < PMIN) pos_q[k] <= PMIN[PW-1:0];
            else                     pos_q[k] <= psum[k][PW-1:0];
          end
        end
        S_G2: begin
          path_q <= (usum > UMAX) ? UMAX[PW-1:0] : usum[PW-1:0];
          if ((dmag_q[0] > DMAG_W'(thr_q)) || (dmag_q[1] > DMAG_W'(thr_q))) begin
            head_q <= hnew;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          raw_q[0] <= $signed(s_axis_tdata[15:0]);
          raw_q[1] <= $signed(s_axis_tdata[31:16]);
          alt_q    <= s_axis_tdata[55:40];
          el_q     <= s_axis_tdata[71:56];
          valid_q  <= ok;
        end
      end
      S_M3: begin
        dmag_q[ax_q] <= smag;
        dneg_q[ax_q] <= raw_q[ax_q][15];
      end
      S_DIV: if (div_done) v_q <= vsat;
      S_F1:  acc_q <= prod;
      S_COR: begin
        if (cor_done) begin
          xr_q <= cx[41:0];
          zr_q <= cz;
        end
      end
      S_G1:  acc_q <= prod;
      S_DONE: begin
        if (out_free) begin
          m_axis_tuser <= valid_q;
          m_axis_tdata <= {path_ext[39:0], head_q, filt_q[1], filt_q[0],
                           py_ext[39:0], px_ext[39:0]};
        end
      end
      default: ;
    endcase
  end

  `ASSERT_STD(a_div_in_div, div_done |-> (state_q == S_DIV), "divider finished out of turn")
  `ASSERT_STD(a_cor_in_cor, cor_done |-> (state_q == S_COR), "cordic finished out of turn")
  `ASSERT_STD(a_reject_fast, (accept && !ok) |=> (state_q == S_DONE), "rejected request not finished")
  `ASSERT_STD(a_load_out, (state_q == S_DONE && out_free) |=> m_axis_tvalid, "result not presented")

endmodule

/* sim/optical_flow_odometry_test.sv */
// ----------------------------------------------------------------------------
// optical_flow_odometry_test
// self-checking bench: streams flow-sensor readings through the block, predicts
// position, velocity, heading and path length for each request and compares
// every returned result field by field, across several register settings
// ----------------------------------------------------------------------------
module optical_flow_odometry_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ofo_pkg::*;

  localparam int LIMIT_CYCLES = 3000000;
  localparam int SETTLE       = 300;

  typedef struct {
    bit       motion;
    bit       clr;
    bit [15:0] dx;
    bit [15:0] dy;
    bit [7:0]  quality;
    bit [15:0] alt;
    bit [15:0] elapsed;
  } reading_t;

  typedef struct {
    bit        valid;
    bit [39:0] pos_x;
    bit [39:0] pos_y;
    bit [31:0] vel_x;
    bit [31:0] vel_y;
    bit [15:0] heading;
    bit [39:0] path_um;
  } odo_t;

  class odometry_scoreboard;
    longint gain, min_q, alpha, thr;
    longint pos_x, pos_y, path_len, vel_x, vel_y;
    bit [15:0] heading;
    odo_t pending[$];
    int errors;

    function new();
      gain = 65536; min_q = 30; alpha = 52429; thr = 1000;
      pos_x = 0; pos_y = 0; path_len = 0; vel_x = 0; vel_y = 0; heading = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [23:0] val);
      case (idx)
        CFG_SCALE_GAIN:   gain  = longint'(val);
        CFG_MIN_QUALITY:  min_q = longint'(val[7:0]);
        CFG_FILTER_ALPHA: alpha = longint'(val[15:0]);
        CFG_MOVE_THR:     thr   = longint'(val[15:0]);
        default: ;
      endcase
    endfunction

    function longint abs64(longint v);
      return (v < 0) ? -v : v;
    endfunction

    function longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint to_um(longint raw, longint alt);
      longint m;
      m = (abs64(raw) * alt * gain + 32768) >>> 16;
      return (raw < 0) ? -m : m;
    endfunction

    function longint lowpass(longint old, longint d, longint el);
      longint v, s, m;
      v = sat32(d / el);
      s = alpha * old + (65536 - alpha) * v;
      m = (abs64(s) + 32768) >>> 16;
      return sat32((s < 0) ? -m : m);
    endfunction

    function longint add_signed_sat(longint a, longint b);
      longint mx, mn;
      mx = (64'sd1 <<< 39) - 1;
      mn = -mx - 1;
      if (a + b > mx) return mx;
      if (a + b < mn) return mn;
      return a + b;
    endfunction

    function void note_reading(reading_t r);
      longint dx, dy, x, y, z, xs, ys, mag, a, umax;
      odo_t e;
      if (r.clr) begin
        pos_x = 0; pos_y = 0; path_len = 0; vel_x = 0; vel_y = 0; heading = 0;
      end
      e.valid = r.motion && (r.quality >= min_q);
      if (e.valid) begin
        dx = to_um(longint'($signed(r.dx)), longint'(r.alt));
        dy = to_um(longint'($signed(r.dy)), longint'(r.alt));
        if (r.elapsed != 0) begin
          vel_x = lowpass(vel_x, dx, longint'(r.elapsed));
          vel_y = lowpass(vel_y, dy, longint'(r.elapsed));
        end
        pos_x = add_signed_sat(pos_x, dx);
        pos_y = add_signed_sat(pos_y, dy);
        x = abs64(dx); y = dy; z = 0;
        for (int i = 0; i < 16; i++) begin
          xs = x >>> i; ys = y >>> i;
          if (y > 0) begin
            x += ys; y -= xs; z += longint'(atan_lut(5'(i)));
          end else if (y < 0) begin
            x -= ys; y += xs; z -= longint'(atan_lut(5'(i)));
          end
        end
        mag = (x * 39797 + 32768) >>> 16;
        umax = (64'sd1 <<< 40) - 1;
        path_len = (path_len + mag > umax) ? umax : path_len + mag;
        if (abs64(dx) > thr || abs64(dy) > thr) begin
          a = (z + 32768) >>> 16;
          if (dx < 0) a = 32768 - a;
          heading = a[15:0];
        end
      end
      e.pos_x = pos_x[39:0]; e.pos_y = pos_y[39:0];
      e.vel_x = vel_x[31:0]; e.vel_y = vel_y[31:0];
      e.heading = heading; e.path_um = path_len[39:0];
      pending.push_back(e);
    endfunction

    function void cmp(string name, longint unsigned e, longint unsigned a);
      if (e != a) begin
        $error("%s expected %0h actual %0h", name, e, a);
        errors++;
      end
    endfunction

    function void check_result(odo_t a);
      odo_t e;
      if (pending.size() == 0) begin
        $error("result with no reading outstanding");
        errors++;
        return;
      end
      e = pending.pop_front();
      cmp("valid_res", e.valid, a.valid);
      cmp("position_x_um", e.pos_x, a.pos_x);
      cmp("position_y_um", e.pos_y, a.pos_y);
      cmp("velocity_x_mms", e.vel_x, a.vel_x);
      cmp("velocity_y_mms", e.vel_y, a.vel_y);
      cmp("heading_angle", e.heading, a.heading);
      cmp("distance_um", e.path_um, a.path_um);
    endfunction
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [71:0]  s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [199:0] m_axis_tdata;
  logic [0:0]   m_axis_tuser;
  logic         cfg_we_i = 1'b0;
  logic [1:0]   cfg_idx_i = '0;
  logic [23:0]  cfg_data_i = '0;

  odometry_scoreboard odo_sb = new();
  bit gaps_on = 1'b1;
  int stall_left = 0;
  int cycles = 0;

  always #10 clk_i = ~clk_i;

  optical_flow_odometry u_dut (.*);

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("optical_flow_odometry test failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 4);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    odo_t r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      r.valid = m_axis_tuser[0];
      r.pos_x = m_axis_tdata[39:0];
      r.pos_y = m_axis_tdata[79:40];
      r.vel_x = m_axis_tdata[111:80];
      r.vel_y = m_axis_tdata[143:112];
      r.heading = m_axis_tdata[159:144];
      r.path_um = m_axis_tdata[199:160];
      odo_sb.check_result(r);
    end
  end

  task automatic send_reading(reading_t r);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {r.elapsed, r.alt, r.quality, r.dy, r.dx};
    s_axis_tuser  <= {r.clr, r.motion};
    do @(posedge clk_i); while (!s_axis_tready);
    odo_sb.note_reading(r);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (odo_sb.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_regs(logic [23:0] g, logic [23:0] q, logic [23:0] a, logic [23:0] t);
    logic [23:0] vals[4];
    vals = '{g, q, a, t};
    drain();
    for (int i = 0; i < 4; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= i[1:0];
      cfg_data_i <= vals[i];
      @(posedge clk_i);
      odo_sb.write_reg(i[1:0], vals[i]);
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic reading_t mk(bit m, int dx, int dy, int q, int alt, int el, bit c);
    reading_t r;
    r.motion = m; r.dx = 16'(dx); r.dy = 16'(dy); r.quality = 8'(q);
    r.alt = 16'(alt); r.elapsed = 16'(el); r.clr = c;
    return r;
  endfunction

  function automatic reading_t rand_reading();
    reading_t r;
    r.motion  = ($urandom_range(0, 9) != 0);
    r.clr     = ($urandom_range(0, 49) == 0);
    r.quality = 8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                               : $urandom_range(30, 255));
    case ($urandom_range(0, 2))
      0: begin r.dx = 16'($urandom); r.dy = 16'($urandom); end
      1: begin
        r.dx = 16'($urandom_range(0, 200) - 100);
        r.dy = 16'($urandom_range(0, 200) - 100);
      end
      default: begin r.dx = 16'($urandom_range(0, 4000) - 2000); r.dy = 16'($urandom); end
    endcase
    r.alt     = 16'(($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 3000));
    r.elapsed = ($urandom_range(0, 7) == 0) ? 16'd0 :
                16'(($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(1, 50));
    return r;
  endfunction

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // default registers
    send_reading(mk(0, 100, 100, 255, 1000, 10, 0));
    send_reading(mk(1, 100, 100, 29, 1000, 10, 0));
    send_reading(mk(1, 100, -50, 30, 1000, 10, 0));
    send_reading(mk(1, 32767, 32767, 255, 65535, 65535, 0));
    send_reading(mk(1, -32768, -32768, 255, 65535, 1, 0));
    send_reading(mk(1, 500, 500, 100, 0, 5, 0));
    send_reading(mk(0, 0, 0, 0, 0, 0, 1));
    send_reading(mk(1, -2000, 0, 100, 1000, 20, 0));
    send_reading(mk(1, 1, 1, 100, 100, 3, 0));
    send_reading(mk(1, 0, 3000, 100, 1000, 0, 0));
    send_reading(mk(1, 0, -3000, 100, 1000, 7, 1));
    send_reading(mk(1, 0, 0, 255, 65535, 65535, 0));
    send_reading(mk(1, 3000, 0, 200, 1000, 9, 0));

    for (int p = 0; p < 7; p++) begin
      case (p)
        0: write_regs(24'd0, 24'd0, 24'd0, 24'd0);
        1: write_regs(24'hFFFFFF, 24'd255, 24'd65535, 24'd65535);
        2: write_regs(24'hFFFFFF, 24'd0, 24'd0, 24'd0);
        3: write_regs(24'd65536, 24'd30, 24'd52429, 24'd1000);
        default: write_regs(24'($urandom_range(0, 24'hFFFFFF)), 24'($urandom_range(0, 255)),
                            24'($urandom), 24'($urandom_range(0, 3000)));
      endcase
      if (p == 6) gaps_on = 1'b0;
      for (int i = 0; i < 100; i++) begin
        if (p == 4 && i == 50) drain();
        send_reading(rand_reading());
      end
    end

    s_axis_tvalid <= 1'b0;
    while (odo_sb.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (odo_sb.errors == 0 && odo_sb.pending.size() == 0) begin
      $display("optical_flow_odometry test passed");
    end else begin
      $display("optical_flow_odometry test failed");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+sv
sv/ofo_pkg.sv
sv/ofo_mul.sv
sv/ofo_div.sv
sv/ofo_cordic.sv
sv/optical_flow_odometry.sv
sim/optical_flow_odometry_test.sv
